@@ rtl/tsbc_pkg.sv @@
// Shared constants and types for the triangle strip backface cull block.
`timescale 1ns / 1ps
`default_nettype none

package tsbc_pkg;

	localparam int unsigned VERTEX_INDEX_BITS_DEF = 16;
	localparam int unsigned COORD_BITS_DEF        = 32;
	localparam int unsigned TRI_NUM_BITS          = 16;
	localparam int unsigned CFG_INDEX_BITS        = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_CAMERA_X = 2'd0,
		CFG_CAMERA_Y = 2'd1,
		CFG_CAMERA_Z = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/tsbc_if.sv @@
// Valid/ready channel interfaces for strip words and cull result words.
`timescale 1ns / 1ps
`default_nettype none

interface tsbc_in_if #(
	parameter int unsigned VERTEX_INDEX_BITS = tsbc_pkg::VERTEX_INDEX_BITS_DEF,
	parameter int unsigned COORD_BITS        = tsbc_pkg::COORD_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          restart;
	logic [VERTEX_INDEX_BITS-1:0]  lead_index;
	logic [VERTEX_INDEX_BITS-1:0]  mid_index;
	logic [VERTEX_INDEX_BITS-1:0]  tail_index;
	logic signed [COORD_BITS-1:0]  point_x;
	logic signed [COORD_BITS-1:0]  point_y;
	logic signed [COORD_BITS-1:0]  point_z;
	logic signed [COORD_BITS-1:0]  normal_x;
	logic signed [COORD_BITS-1:0]  normal_y;
	logic signed [COORD_BITS-1:0]  normal_z;
	logic                          final_triangle;

	modport source (
		output valid, restart, lead_index, mid_index, tail_index,
		output point_x, point_y, point_z, normal_x, normal_y, normal_z, final_triangle,
		input  ready
	);
	modport sink (
		input  valid, restart, lead_index, mid_index, tail_index,
		input  point_x, point_y, point_z, normal_x, normal_y, normal_z, final_triangle,
		output ready
	);
endinterface

interface tsbc_out_if #(
	parameter int unsigned VERTEX_INDEX_BITS = tsbc_pkg::VERTEX_INDEX_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [tsbc_pkg::TRI_NUM_BITS-1:0] triangle_number;
	logic                              visible;
	logic [VERTEX_INDEX_BITS-1:0]      vertex_a;
	logic [VERTEX_INDEX_BITS-1:0]      vertex_b;
	logic [VERTEX_INDEX_BITS-1:0]      vertex_c;
	logic                              last;

	modport source (
		output valid, triangle_number, visible, vertex_a, vertex_b, vertex_c, last,
		input  ready
	);
	modport sink (
		input  valid, triangle_number, visible, vertex_a, vertex_b, vertex_c, last,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/tsbc_strip.sv @@
// Strip index tracker: picks the triangle's three indices and keeps the running count.
`timescale 1ns / 1ps
`default_nettype none

module tsbc_strip #(
	parameter int unsigned VERTEX_INDEX_BITS = tsbc_pkg::VERTEX_INDEX_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic                              restart,
	input  wire logic                              final_triangle,
	input  wire logic [VERTEX_INDEX_BITS-1:0]      lead_index,
	input  wire logic [VERTEX_INDEX_BITS-1:0]      mid_index,
	input  wire logic [VERTEX_INDEX_BITS-1:0]      tail_index,
	output logic      [VERTEX_INDEX_BITS-1:0]      vertex_a,
	output logic      [VERTEX_INDEX_BITS-1:0]      vertex_b,
	output logic      [VERTEX_INDEX_BITS-1:0]      vertex_c,
	output logic      [tsbc_pkg::TRI_NUM_BITS-1:0] triangle_number
);

	logic [VERTEX_INDEX_BITS-1:0]      held_first_q;
	logic [VERTEX_INDEX_BITS-1:0]      held_second_q;
	logic [tsbc_pkg::TRI_NUM_BITS-1:0] count_q;

	// Without a restart the word's lead index is the new third vertex.
	always_comb begin
		if (restart) begin
			vertex_a = lead_index;
			vertex_b = mid_index;
			vertex_c = tail_index;
		end else begin
			vertex_a = held_first_q;
			vertex_b = held_second_q;
			vertex_c = lead_index;
		end
	end

	assign triangle_number = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_first_q  <= '0;
			held_second_q <= '0;
			count_q       <= '0;
		end else if (accept) begin
			if (final_triangle) begin
				held_first_q  <= '0;
				held_second_q <= '0;
				count_q       <= '0;
			end else begin
				held_first_q  <= vertex_b;
				held_second_q <= vertex_c;
				count_q       <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tsbc_dot.sv @@
// Four-stage pipeline that forms (camera - point) . normal exactly and tests its sign.
`timescale 1ns / 1ps
`default_nettype none

module tsbc_dot #(
	parameter int unsigned COORD_BITS = tsbc_pkg::COORD_BITS_DEF,
	parameter int unsigned META_BITS  = 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire logic                         in_valid,
	input  wire logic signed [COORD_BITS-1:0] camera [3],
	input  wire logic signed [COORD_BITS-1:0] point [3],
	input  wire logic signed [COORD_BITS-1:0] normal [3],
	input  wire logic        [META_BITS-1:0]  meta_in,
	output logic                              out_valid,
	output logic                              visible,
	output logic             [META_BITS-1:0]  meta_out
);

	localparam int unsigned DW  = COORD_BITS + 1;     // difference width
	localparam int unsigned LO  = COORD_BITS / 2;     // low half of the normal
	localparam int unsigned HI  = COORD_BITS - LO;    // high half of the normal
	localparam int unsigned PLW = DW + LO + 1;        // low partial product
	localparam int unsigned PHW = DW + HI;            // high partial product
	localparam int unsigned PW  = DW + COORD_BITS;    // full product
	localparam int unsigned SW  = PW + 2;             // sum of three products

	logic                       vld_s1, vld_s2, vld_s3, vld_s4;
	logic [META_BITS-1:0]       meta_s1, meta_s2, meta_s3, meta_s4;
	logic signed [DW-1:0]       diff_s1 [3];
	logic signed [COORD_BITS-1:0] nrm_s1 [3];
	logic signed [PLW-1:0]      plo_s2 [3];
	logic signed [PHW-1:0]      phi_s2 [3];
	logic signed [PW-1:0]       prod_s3 [3];
	logic                       visible_s4;
	logic signed [SW-1:0]       sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_axis
		// The normal is split in halves so that each multiplier stays about half width.
		// The high half carries the sign of the normal.
		always_ff @(posedge clk) begin
			if (advance) begin
				diff_s1[i] <= DW'(camera[i]) - DW'(point[i]);
				nrm_s1[i]  <= normal[i];
				plo_s2[i]  <= PLW'(diff_s1[i]) * PLW'($signed({1'b0, nrm_s1[i][LO-1:0]}));
				phi_s2[i]  <= PHW'(diff_s1[i]) * PHW'($signed(nrm_s1[i][COORD_BITS-1:LO]));
				prod_s3[i] <= (PW'(phi_s2[i]) <<< LO) + PW'(plo_s2[i]);
			end
		end
	end

	assign sum = SW'(prod_s3[0]) + SW'(prod_s3[1]) + SW'(prod_s3[2]);

	always_ff @(posedge clk) begin
		if (advance) begin
			meta_s1    <= meta_in;
			meta_s2    <= meta_s1;
			meta_s3    <= meta_s2;
			meta_s4    <= meta_s3;
			visible_s4 <= ~sum[SW-1];
		end
	end

	assign out_valid = vld_s4;
	assign visible   = visible_s4;
	assign meta_out  = meta_s4;

endmodule

`default_nettype wire

@@ rtl/triangle_strip_backface_cull.sv @@
// Top level of the triangle strip backface cull block.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+------------------------------------------
//   strip    | in  | valid / ready    | restart, three indices, point, normal, final
//   result   | out | valid / ready    | triangle number, visible, three indices, last
//   cfg      | in  | cfg_wr_en        | cfg_index selects camera x, y or z
//
// One strip word is taken every cycle while no output word waits; its result word is valid
// once it has passed through every register of the dot product pipeline in order:
// difference, half-width partial products, per-axis products, then the three-way sum
// and sign test.
// Reset clears the camera registers, the held strip indices and the triangle count.
// When the output word waits, every stage holds and ready drops for that cycle.
`timescale 1ns / 1ps
`default_nettype none

module triangle_strip_backface_cull #(
	parameter int unsigned VERTEX_INDEX_BITS = tsbc_pkg::VERTEX_INDEX_BITS_DEF,
	parameter int unsigned COORD_BITS        = tsbc_pkg::COORD_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	tsbc_in_if.sink                                  strip,
	tsbc_out_if.source                               result,
	input  wire logic                                cfg_wr_en,
	input  wire logic [tsbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [COORD_BITS-1:0]               cfg_data
);

	localparam int unsigned META_BITS = tsbc_pkg::TRI_NUM_BITS + 3 * VERTEX_INDEX_BITS + 1;

	logic signed [COORD_BITS-1:0]      camera_q [3];
	logic signed [COORD_BITS-1:0]      point [3];
	logic signed [COORD_BITS-1:0]      normal [3];
	logic                              advance;
	logic                              accept;
	logic [VERTEX_INDEX_BITS-1:0]      sel_va, sel_vb, sel_vc;
	logic [tsbc_pkg::TRI_NUM_BITS-1:0] cur_number;
	logic [META_BITS-1:0]              meta_in, meta_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_q[0] <= '0;
			camera_q[1] <= '0;
			camera_q[2] <= '0;
		end else if (cfg_wr_en) begin
			unique case (tsbc_pkg::cfg_reg_t'(cfg_index))
				tsbc_pkg::CFG_CAMERA_X: camera_q[0] <= cfg_data;
				tsbc_pkg::CFG_CAMERA_Y: camera_q[1] <= cfg_data;
				tsbc_pkg::CFG_CAMERA_Z: camera_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished word is waiting at the output.
	assign advance     = !result.valid || result.ready;
	assign strip.ready = advance;
	assign accept      = strip.valid && advance;

	tsbc_strip #(
		.VERTEX_INDEX_BITS (VERTEX_INDEX_BITS)
	) u_strip (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.restart         (strip.restart),
		.final_triangle  (strip.final_triangle),
		.lead_index      (strip.lead_index),
		.mid_index       (strip.mid_index),
		.tail_index      (strip.tail_index),
		.vertex_a        (sel_va),
		.vertex_b        (sel_vb),
		.vertex_c        (sel_vc),
		.triangle_number (cur_number)
	);

	assign point[0]  = strip.point_x;
	assign point[1]  = strip.point_y;
	assign point[2]  = strip.point_z;
	assign normal[0] = strip.normal_x;
	assign normal[1] = strip.normal_y;
	assign normal[2] = strip.normal_z;
	assign meta_in   = {cur_number, sel_va, sel_vb, sel_vc, strip.final_triangle};

	tsbc_dot #(
		.COORD_BITS (COORD_BITS),
		.META_BITS  (META_BITS)
	) u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (accept),
		.camera    (camera_q),
		.point     (point),
		.normal    (normal),
		.meta_in   (meta_in),
		.out_valid (result.valid),
		.visible   (result.visible),
		.meta_out  (meta_out)
	);

	assign {result.triangle_number, result.vertex_a, result.vertex_b,
		result.vertex_c, result.last} = meta_out;

	// A final triangle leaves the strip empty and the count at zero.
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && strip.final_triangle |=> cur_number == '0)
		else $error("triangle count not cleared after final triangle");

	// A continued strip slides the last two indices of the previous triangle forward.
	a_strip_slides: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !strip.final_triangle |=>
		strip.restart || (sel_va == $past(sel_vb) && sel_vb == $past(sel_vc)))
		else $error("strip indices did not slide");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !strip.final_triangle |=>
		cur_number == $past(cur_number) + 1'b1)
		else $error("triangle count did not advance");

	// The result side can only hold a word while the input side is stalled.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !strip.ready)
		else $error("input taken while output word waits");

endmodule

`default_nettype wire
